### rtl/core/bnc_pkg.sv
// Shared constants for the bit necklace classifier.
`timescale 1ns / 1ps
`default_nettype none

package bnc_pkg;

    localparam int unsigned MAX_BITS_DEF = 32;
    localparam int unsigned LEN_W        = 6;
    localparam int unsigned DATA_W       = 32;
    localparam logic [LEN_W-1:0] LEN_RESET = 6'd8;
    localparam int unsigned OUT_USED     = 2 * DATA_W + DATA_W + LEN_W + 5;
    localparam int unsigned OUT_W        = ((OUT_USED + 7) / 8) * 8;

endpackage

`default_nettype wire

### rtl/core/bnc_rot_compare.sv
// Rotation set, rotation compares, link, sublink and parity of one masked loop.
`timescale 1ns / 1ps
`default_nettype none

module bnc_rot_compare #(
    parameter int unsigned W  = bnc_pkg::MAX_BITS_DEF,
    parameter int unsigned LW = $clog2(W + 1)
) (
    input  logic [W-1:0]  x,
    input  logic [W-1:0]  m,
    input  logic [LW-1:0] n,
    output logic [W-1:0]  rot [W],
    output logic [W-1:0]  eq_x,
    output logic [W-1:0]  eq_rev,
    output logic [W-1:0]  eq_cmp,
    output logic [W-1:0]  link,
    output logic [W-1:0]  sub,
    output logic          par,
    output logic          pal
);

    logic [2*W-1:0] dbl;
    logic [W-1:0]   rev_full;
    logic [W-1:0]   rev;
    logic [W-1:0]   cmp;
    logic [W-1:0]   rot_raw [W];

    always_comb
    begin
        dbl = {{W{1'b0}}, x} | ({{W{1'b0}}, x} << n);
        for (int i = 0; i < W; i++)
        begin
            rev_full[i] = x[W-1-i];
        end
        rev  = rev_full >> (LW'(W) - n);
        cmp  = ~x & m;
        par  = ^x;
        pal  = (rev == x);
        link = (x ^ dbl[W:1]) & m;
        for (int j = 0; j < W; j++)
        begin
            rot_raw[j] = dbl[j +: W] & m;
            rot[j]     = m[j] ? rot_raw[j] : x;
            eq_x[j]    = m[j] && (rot_raw[j] == x);
            eq_rev[j]  = m[j] && (rot_raw[j] == rev);
            eq_cmp[j]  = m[j] && (rot_raw[j] == cmp);
        end
        sub[0] = 1'b0;
        for (int k = 1; k < W; k++)
        begin
            sub[k] = m[k] & (^(x & ({W{1'b1}} >> (W - k))));
        end
        if (par)
        begin
            sub = '0;
        end
    end

endmodule

`default_nettype wire

### rtl/core/bit_necklace_classifier_unit.sv
// Bit necklace classifier: top level with item pipeline and minimum tree.
//
// Usage:
//   cfg_valid/cfg_ready/cfg_data write the loop length (1..MAX_BITS; 0 acts
//   as 1, larger values as MAX_BITS). cfg_ready is always high. Write it
//   only while no item is in flight.
//   s_tvalid/s_tready/s_tdata carry one loop word per item; bits at and
//   above the loop length are ignored.
//   m_tvalid/m_tready/m_tdata return one result item per input item.
// Pipeline: an input stage, a rotation/compare stage, then one register per
//   level of the binary minimum tree over rotations.
// Throughput: one item per cycle while m_tready is high; every stage then
//   takes a new item each cycle.
// Stall: a held m_tready freezes the last stage; earlier stages keep filling
//   empty slots, then s_tready drops when the whole pipeline is full.
// Reset: all stages empty, loop length back to 8.
`timescale 1ns / 1ps
`default_nettype none

module bit_necklace_classifier_unit #(
    parameter int unsigned MAX_BITS = bnc_pkg::MAX_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [bnc_pkg::LEN_W-1:0]  cfg_data,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // loop_bits[31:0]
    input  logic [bnc_pkg::DATA_W-1:0] s_tdata,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // min_rotation[31:0], period[37:32], odd_parity[38], mirror_symmetric[39],
    // palindrome[40], self_complement[41], link_word[73:42],
    // sublink_word[105:74], sublink_valid[106], zero pad[111:107]
    output logic [bnc_pkg::OUT_W-1:0]  m_tdata
);

    import bnc_pkg::*;

    localparam int unsigned W  = MAX_BITS;
    localparam int unsigned LW = $clog2(W + 1);
    localparam int unsigned LV = $clog2(W);
    localparam int unsigned P  = 1 << LV;
    localparam int unsigned NS = LV + 2;
    localparam int unsigned PAD_W = OUT_W - OUT_USED;

    logic [LEN_W-1:0] cfg_len_reg;
    logic [LW-1:0]    n_eff;
    logic [W-1:0]     mask;
    logic [W+DATA_W-1:0] x_wide;
    logic [W-1:0]     x_in;

    logic [NS-1:0]    vld_reg;
    logic [NS-1:0]    rdy;

    logic [W-1:0]     a_x_reg;
    logic [W-1:0]     a_m_reg;
    logic [LW-1:0]    a_n_reg;

    logic [W-1:0]     rot_w [W];
    logic [W-1:0]     eq_x_w;
    logic [W-1:0]     eq_rev_w;
    logic [W-1:0]     eq_cmp_w;
    logic [W-1:0]     link_w;
    logic [W-1:0]     sub_w;
    logic             par_w;
    logic             pal_w;

    logic [W-1:0]     b_rot_reg [W];
    logic [W-1:0]     b_eq_x_reg;
    logic [W-1:0]     b_eq_rev_reg;
    logic [W-1:0]     b_eq_cmp_reg;
    logic [W-1:0]     b_link_reg;
    logic [W-1:0]     b_sub_reg;
    logic             b_par_reg;
    logic             b_pal_reg;
    logic [LW-1:0]    b_n_reg;

    logic [W-1:0]     node_w [1:2*P-1];
    logic [W-1:0]     heap_reg [1:P-1];

    logic [LW-1:0]    per_next;
    logic             mir_next;
    logic             slf_next;

    logic [LW-1:0]    t_per_reg  [LV];
    logic             t_par_reg  [LV];
    logic             t_mir_reg  [LV];
    logic             t_pal_reg  [LV];
    logic             t_slf_reg  [LV];
    logic [W-1:0]     t_link_reg [LV];
    logic [W-1:0]     t_sub_reg  [LV];

    logic [W+DATA_W-1:0]  min_wide;
    logic [W+DATA_W-1:0]  link_wide;
    logic [W+DATA_W-1:0]  sub_wide;
    logic [LW+LEN_W-1:0]  per_wide;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_len_reg <= LEN_RESET;
        end
        else if (cfg_valid)
        begin
            cfg_len_reg <= cfg_data;
        end
    end

    always_comb
    begin
        if (cfg_len_reg == '0)
        begin
            n_eff = LW'(1);
        end
        else if (int'(cfg_len_reg) > int'(W))
        begin
            n_eff = LW'(W);
        end
        else
        begin
            n_eff = LW'(cfg_len_reg);
        end
        for (int j = 0; j < W; j++)
        begin
            mask[j] = (LW'(j) < n_eff);
        end
        x_wide = {{W{1'b0}}, s_tdata};
        x_in   = x_wide[W-1:0] & mask;
    end

    // Handshake: a stage takes a new item when empty or when its item moves on.
    always_comb
    begin
        rdy[NS-1] = !vld_reg[NS-1] || m_tready;
        for (int i = NS - 2; i >= 0; i--)
        begin
            rdy[i] = !vld_reg[i] || rdy[i+1];
        end
    end

    assign s_tready = rdy[0];
    assign m_tvalid = vld_reg[NS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                vld_reg[0] <= s_tvalid;
            end
            for (int i = 1; i < NS; i++)
            begin
                if (rdy[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            a_x_reg <= x_in;
            a_m_reg <= mask;
            a_n_reg <= n_eff;
        end
    end

    bnc_rot_compare #(
        .W  (W),
        .LW (LW)
    ) u_rot_compare (
        .x      (a_x_reg),
        .m      (a_m_reg),
        .n      (a_n_reg),
        .rot    (rot_w),
        .eq_x   (eq_x_w),
        .eq_rev (eq_rev_w),
        .eq_cmp (eq_cmp_w),
        .link   (link_w),
        .sub    (sub_w),
        .par    (par_w),
        .pal    (pal_w)
    );

    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            for (int j = 0; j < W; j++)
            begin
                b_rot_reg[j] <= rot_w[j];
            end
            b_eq_x_reg   <= eq_x_w;
            b_eq_rev_reg <= eq_rev_w;
            b_eq_cmp_reg <= eq_cmp_w;
            b_link_reg   <= link_w;
            b_sub_reg    <= sub_w;
            b_par_reg    <= par_w;
            b_pal_reg    <= pal_w;
            b_n_reg      <= a_n_reg;
        end
    end

    // Smallest shift that maps the loop onto itself; it always divides the length.
    always_comb
    begin
        per_next = b_n_reg;
        for (int k = W - 1; k >= 1; k--)
        begin
            if (b_eq_x_reg[k])
            begin
                per_next = LW'(k);
            end
        end
        mir_next = |b_eq_rev_reg;
        slf_next = |b_eq_cmp_reg;
    end

    // Heap layout: node k takes the smaller of nodes 2k and 2k+1; leaves start at P.
    always_comb
    begin
        for (int k = 1; k < P; k++)
        begin
            node_w[k] = heap_reg[k];
        end
        for (int i = 0; i < P; i++)
        begin
            node_w[P+i] = (i < W) ? b_rot_reg[i] : b_rot_reg[0];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int l = 0; l < LV; l++)
        begin
            if (rdy[2+l])
            begin
                for (int k = (P >> (l + 1)); k < (P >> l); k++)
                begin
                    heap_reg[k] <= (node_w[2*k+1] < node_w[2*k]) ? node_w[2*k+1]
                                                                : node_w[2*k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[2])
        begin
            t_per_reg[0]  <= per_next;
            t_par_reg[0]  <= b_par_reg;
            t_mir_reg[0]  <= mir_next;
            t_pal_reg[0]  <= b_pal_reg;
            t_slf_reg[0]  <= slf_next;
            t_link_reg[0] <= b_link_reg;
            t_sub_reg[0]  <= b_sub_reg;
        end
        for (int l = 1; l < LV; l++)
        begin
            if (rdy[2+l])
            begin
                t_per_reg[l]  <= t_per_reg[l-1];
                t_par_reg[l]  <= t_par_reg[l-1];
                t_mir_reg[l]  <= t_mir_reg[l-1];
                t_pal_reg[l]  <= t_pal_reg[l-1];
                t_slf_reg[l]  <= t_slf_reg[l-1];
                t_link_reg[l] <= t_link_reg[l-1];
                t_sub_reg[l]  <= t_sub_reg[l-1];
            end
        end
    end

    always_comb
    begin
        min_wide  = {{DATA_W{1'b0}}, heap_reg[1]};
        link_wide = {{DATA_W{1'b0}}, t_link_reg[LV-1]};
        sub_wide  = {{DATA_W{1'b0}}, t_sub_reg[LV-1]};
        per_wide  = {{LEN_W{1'b0}}, t_per_reg[LV-1]};
        m_tdata   = {{PAD_W{1'b0}},
                     ~t_par_reg[LV-1],
                     sub_wide[DATA_W-1:0],
                     link_wide[DATA_W-1:0],
                     t_slf_reg[LV-1],
                     t_pal_reg[LV-1],
                     t_mir_reg[LV-1],
                     t_par_reg[LV-1],
                     per_wide[LEN_W-1:0],
                     min_wide[DATA_W-1:0]};
    end

endmodule

`default_nettype wire
